[rtl/dco_frequency_trim_assert.svh]
// Assertion macros shared by the checker of the oscillator trim block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DCO_FREQUENCY_TRIM_ASSERT_SVH
`define DCO_FREQUENCY_TRIM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dco_frequency_trim: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dco_frequency_trim: next-cycle check failed");

`endif

[rtl/dft_pkg.sv]
// Package for the oscillator trim block: widths, codes and shared types.
// No dependencies; used by dft_divider and dco_frequency_trim.
`default_nettype none

package dft_pkg;

    localparam int MAX_TRIES      = 4096;
    localparam int SAMPLE_PERIODS = 10;

    localparam int TFREQ_W = 25;
    localparam int RFREQ_W = 16;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 25;
    localparam int CFG_A_W = 2;

    // Numerator of the target division and its iteration count.
    localparam int NUM_W   = TFREQ_W + $clog2(SAMPLE_PERIODS + 1);
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int TRIES_W = $clog2(MAX_TRIES + 1);

    localparam logic [TFREQ_W-1:0] TFREQ_RST = TFREQ_W'(1000000);
    localparam logic [RFREQ_W-1:0] RFREQ_RST = RFREQ_W'(32768);
    localparam logic [BYTE_W-1:0]  MOD_RST   = BYTE_W'(96);
    localparam logic [BYTE_W-1:0]  RANGE_RST = BYTE_W'(135);

    typedef enum logic [CFG_A_W-1:0] {
        CFG_TARGET_FREQ = 2'd0,
        CFG_REF_FREQ    = 2'd1,
        CFG_START_MOD   = 2'd2,
        CFG_START_RANGE = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_MEASURE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ADJUSTING = 2'd0,
        ST_LOCKED    = 2'd1,
        ST_TIMEOUT   = 2'd2,
        ST_IDLE      = 2'd3
    } trim_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/dft_divider.sv]
// Restoring serial divider: one quotient bit per cycle, low bits kept.
// Depends on dft_pkg.
`default_nettype none

module dft_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dft_pkg::NUM_W-1:0]    dividend,
    input  wire logic [dft_pkg::RFREQ_W-1:0]  divisor,
    output dft_pkg::div_stat_t                stat,
    output logic      [dft_pkg::TICK_W-1:0]   quotient
);
    import dft_pkg::*;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [RFREQ_W-1:0] den_reg;
    logic [RFREQ_W-1:0] rem_reg;
    logic [TICK_W-1:0]  quot_reg;

    logic [RFREQ_W:0]   trial;
    logic [RFREQ_W:0]   diff;
    logic               ge;

    // With a zero divisor every trial succeeds, so the quotient is all ones.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= ge ? diff[RFREQ_W-1:0] : trial[RFREQ_W-1:0];
            quot_reg <= {quot_reg[TICK_W-2:0], ge};
        end
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

`default_nettype wire

[rtl/dco_frequency_trim.sv]
// Frequency-locked trim of an oscillator modulation and range setting.
// A measurement item yields its result item in the output register in the cycle after it
// is accepted, and a new item may be accepted in that same cycle if m_tready is high.
// A start item passes through S_DIV and S_OUT: one serial divider stage produces one
// quotient bit per cycle, and the block is not ready meanwhile.
// Reset (async, active low) restores register defaults and idles the trim loop.
// Depends on dft_pkg and dft_divider.
`default_nettype none

module dco_frequency_trim (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dft_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [dft_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] measured_ticks
    input  wire logic                          s_tuser,   // [0] command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [31:0]                   m_tdata,   // [7:0] modulation,
                                                          // [15:8] range_sel,
                                                          // [31:16] target_ticks
    output logic      [1:0]                    m_tuser    // [1:0] status
);
    import dft_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [TFREQ_W-1:0] tfreq_reg;
    logic [RFREQ_W-1:0] rfreq_reg;
    logic [BYTE_W-1:0]  smod_reg;
    logic [BYTE_W-1:0]  srange_reg;

    logic [BYTE_W-1:0]  mod_reg, mod_next;
    logic [BYTE_W-1:0]  range_reg, range_next;
    logic [TRIES_W-1:0] tries_reg, tries_next;
    logic [TICK_W-1:0]  target_reg;
    logic               active_reg, active_next;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_mod_reg;
    logic [BYTE_W-1:0]  out_range_reg;
    logic [TICK_W-1:0]  out_target_reg;
    trim_status_t       out_status_reg;

    logic               s_accept;
    logic               out_free;
    logic               meas_accept;
    logic               div_start;
    logic               div_load;
    logic [NUM_W-1:0]   numerator;
    logic [TICK_W-1:0]  quotient;
    div_stat_t          div_stat;
    logic [TRIES_W-1:0] tries_inc;
    trim_status_t       meas_status;

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == S_IDLE) && out_free && !div_stat.busy;
    assign s_accept    = s_tvalid && s_tready;
    assign div_start   = s_accept && (cmd_t'(s_tuser) == CMD_START);
    assign meas_accept = s_accept && (cmd_t'(s_tuser) == CMD_MEASURE);
    assign div_load    = (state_reg == S_OUT) && out_free;
    assign numerator   = NUM_W'(tfreq_reg) * NUM_W'(SAMPLE_PERIODS);

    dft_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numerator),
        .divisor  (rfreq_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Trim step for a measurement item, and the load of the start setting for a start item.
    assign tries_inc = tries_reg + 1'b1;

    always_comb
    begin
        mod_next    = mod_reg;
        range_next  = range_reg;
        tries_next  = tries_reg;
        active_next = active_reg;
        meas_status = ST_IDLE;
        if (div_start)
        begin
            mod_next    = smod_reg;
            range_next  = srange_reg;
            tries_next  = '0;
            active_next = 1'b1;
        end
        else if (meas_accept && active_reg)
        begin
            tries_next = tries_inc;
            if (s_tdata == target_reg)
            begin
                active_next = 1'b0;
                meas_status = ST_LOCKED;
            end
            else
            begin
                if (s_tdata > target_reg)
                begin
                    mod_next = mod_reg - 1'b1;
                    if (mod_reg == '0)
                    begin
                        range_next = range_reg - 1'b1;
                    end
                end
                else
                begin
                    mod_next = mod_reg + 1'b1;
                    if (mod_reg == '1)
                    begin
                        range_next = range_reg + 1'b1;
                    end
                end
                if (tries_inc >= TRIES_W'(MAX_TRIES))
                begin
                    active_next = 1'b0;
                    meas_status = ST_TIMEOUT;
                end
                else
                begin
                    meas_status = ST_ADJUSTING;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tfreq_reg     <= TFREQ_RST;
            rfreq_reg     <= RFREQ_RST;
            smod_reg      <= MOD_RST;
            srange_reg    <= RANGE_RST;
            mod_reg       <= MOD_RST;
            range_reg     <= RANGE_RST;
            tries_reg     <= '0;
            target_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            range_reg     <= range_next;
            tries_reg     <= tries_next;
            active_reg    <= active_next;
            out_valid_reg <= meas_accept || div_load || !out_free;
            if (div_load)
            begin
                target_reg <= quotient;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_TARGET_FREQ: tfreq_reg  <= cfg_wdata[TFREQ_W-1:0];
                    CFG_REF_FREQ:    rfreq_reg  <= cfg_wdata[RFREQ_W-1:0];
                    CFG_START_MOD:   smod_reg   <= cfg_wdata[BYTE_W-1:0];
                    CFG_START_RANGE: srange_reg <= cfg_wdata[BYTE_W-1:0];
                    default:         tfreq_reg  <= tfreq_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_accept)
        begin
            out_mod_reg    <= mod_next;
            out_range_reg  <= range_next;
            out_target_reg <= target_reg;
            out_status_reg <= meas_status;
        end
        else if (div_load)
        begin
            out_mod_reg    <= mod_reg;
            out_range_reg  <= range_reg;
            out_target_reg <= quotient;
            out_status_reg <= ST_ADJUSTING;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_target_reg, out_range_reg, out_mod_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

[rtl/dft_checker.sv]
// Port-level checks of the oscillator trim block, bound to its top level.
// Depends on dco_frequency_trim_assert.svh and dco_frequency_trim.
`default_nettype none

`include "dco_frequency_trim_assert.svh"

module dft_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    // The input side only opens when the output register can take a result.
    `DFT_ASSERT_SAME(a_ready_needs_room, clk, rst_n, s_tready, !m_tvalid || m_tready)

    // A measurement item shows its result item in the next cycle.
    `DFT_ASSERT_NEXT(a_meas_result, clk, rst_n, s_tvalid && s_tready && s_tuser, m_tvalid)

    // A start item occupies the divider, so the input side closes.
    `DFT_ASSERT_NEXT(a_start_busy, clk, rst_n, s_tvalid && s_tready && !s_tuser, !s_tready)

    // A stalled result item holds its payload.
    `DFT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind dco_frequency_trim dft_checker u_dft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
